// ===== rtl/ctw_pkg.sv =====
// Shared types, constants and address helper for the text console writer.
// Used by every module of the block but ctw_ram; depends on nothing.
`default_nettype none
package ctw_pkg;
   localparam int COLUMNS   = 80;
   localparam int ROWS      = 25;
   localparam int TAB_WIDTH = 8;
   localparam int CELLS     = ROWS * COLUMNS;

   localparam int ADDR_W  = $clog2(CELLS);
   localparam int ROW_W   = (ROWS > 2) ? $clog2(ROWS) : 1;
   localparam int COL_W   = $clog2(COLUMNS);
   localparam int PHASE_W = $clog2(TAB_WIDTH);
   localparam int NCOL_W  = $clog2(COLUMNS + TAB_WIDTH) + 1;
   localparam int POS_W   = (ADDR_W > 11) ? ADDR_W : 11;

   localparam logic [7:0] CH_BS    = 8'd8;
   localparam logic [7:0] CH_TAB   = 8'd9;
   localparam logic [7:0] CH_NL    = 8'd10;
   localparam logic [7:0] CH_CR    = 8'd13;
   localparam logic [7:0] CH_BLANK = 8'h20;

   localparam logic [3:0] RESET_FG = 4'd7;
   localparam logic [3:0] RESET_BG = 4'd0;

   localparam logic CSR_FG = 1'b0;
   localparam logic CSR_BG = 1'b1;

   localparam logic [1:0] CMD_PUT   = 2'd0;
   localparam logic [1:0] CMD_READ  = 2'd1;
   localparam logic [1:0] CMD_CLEAR = 2'd2;

   typedef enum logic [2:0] {
      OP_CHAR, OP_NL, OP_CR, OP_TAB, OP_BS, OP_READ, OP_CLEAR, OP_NOP
   } op_type;

   typedef struct packed {
      op_type            op;
      logic [7:0]        char_code;
      logic [ADDR_W-1:0] read_addr;
      logic              read_ok;
   } item_type;

   typedef struct packed {
      logic     valid;
      item_type item;
   } queue_head_type;

   typedef struct packed {
      logic pop;
      logic init_busy;
   } back_status_type;

   function automatic logic [POS_W-1:0] cell_addr(input logic [ROW_W-1:0] row,
                                                  input logic [COL_W-1:0] col);
      cell_addr = POS_W'(row) * POS_W'(COLUMNS) + POS_W'(col);
   endfunction
endpackage
`default_nettype wire

// ===== rtl/text_console_writer.sv =====
// Requests are taken one per cycle while busy is low, into a two-entry queue; the back
// end pops an item only when idle, so reads, scrolls and clears hold the queue back.
// Reset: synchronous; after it a clearing pass over the whole store holds busy high.
// Results are strobed for one cycle on rsp_valid; the receiver cannot stall.
// Top level: color registers, front end, back end. Depends on ctw_pkg, ctw_front and ctw_back.
`default_nettype none
module text_console_writer (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [1:0]  req_cmd,
   input  wire logic [7:0]  req_char_code,
   input  wire logic [4:0]  req_read_row,
   input  wire logic [6:0]  req_read_col,
   output logic             rsp_valid,
   output logic [15:0]      rsp_cell_value,
   output logic [10:0]      rsp_cursor_position,
   output logic             rsp_scrolled,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic        csr_index,
   input  wire logic [3:0]  csr_wdata
);
   import ctw_pkg::*;

   logic [3:0]      fg_ff, bg_ff;
   queue_head_type  head;
   back_status_type status;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         fg_ff <= RESET_FG;
         bg_ff <= RESET_BG;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_FG:  fg_ff <= csr_wdata;
            default: bg_ff <= csr_wdata;
         endcase
      end
   end

   ctw_front u_front (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_cmd       (req_cmd),
      .req_char_code (req_char_code),
      .req_read_row  (req_read_row),
      .req_read_col  (req_read_col),
      .status        (status),
      .head          (head)
   );

   ctw_back u_back (
      .clock               (clock),
      .reset               (reset),
      .fg_color            (fg_ff),
      .bg_color            (bg_ff),
      .head                (head),
      .status              (status),
      .rsp_valid           (rsp_valid),
      .rsp_cell_value      (rsp_cell_value),
      .rsp_cursor_position (rsp_cursor_position),
      .rsp_scrolled        (rsp_scrolled)
   );
endmodule
`default_nettype wire

// ===== rtl/ctw_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module ctw_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 2000
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;
endmodule
`default_nettype wire

// ===== rtl/ctw_front.sv =====
// Front end: takes requests, decodes them and holds them in a two-entry queue.
// Depends on ctw_pkg.
`default_nettype none
module ctw_front (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     start,
   output logic                          busy,
   input  wire logic [1:0]               req_cmd,
   input  wire logic [7:0]               req_char_code,
   input  wire logic [4:0]               req_read_row,
   input  wire logic [6:0]               req_read_col,
   input  wire ctw_pkg::back_status_type status,
   output ctw_pkg::queue_head_type       head
);
   import ctw_pkg::*;

   item_type   slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   item_type   dec;
   logic       push;

   always_comb begin
      dec.char_code = req_char_code;
      dec.read_ok   = (32'(req_read_row) < ROWS) && (32'(req_read_col) < COLUMNS);
      dec.read_addr = ADDR_W'(cell_addr(ROW_W'(req_read_row), COL_W'(req_read_col)));
      case (req_cmd)
         CMD_PUT: begin
            case (req_char_code)
               CH_NL:   dec.op = OP_NL;
               CH_CR:   dec.op = OP_CR;
               CH_TAB:  dec.op = OP_TAB;
               CH_BS:   dec.op = OP_BS;
               default: dec.op = OP_CHAR;
            endcase
         end
         CMD_READ:  dec.op = OP_READ;
         CMD_CLEAR: dec.op = OP_CLEAR;
         default:   dec.op = OP_NOP;
      endcase
   end

   assign busy = (count_ff == 2'd2) || status.init_busy;
   assign push = start && !busy;

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = status.pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(status.pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= dec;
      end
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   assign head.valid = (count_ff != 2'd0);
   assign head.item  = slot_ff[rd_ptr_ff];
endmodule
`default_nettype wire

// ===== rtl/ctw_back.sv =====
// Back end: cursor, screen store sequencer (put, read, scroll, clear) and response.
// Depends on ctw_pkg and ctw_ram.
`default_nettype none
module ctw_back (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic [3:0]              fg_color,
   input  wire logic [3:0]              bg_color,
   input  wire ctw_pkg::queue_head_type head,
   output ctw_pkg::back_status_type     status,
   output logic                         rsp_valid,
   output logic [15:0]                  rsp_cell_value,
   output logic [10:0]                  rsp_cursor_position,
   output logic                         rsp_scrolled
);
   import ctw_pkg::*;

   typedef enum logic [2:0] {S_IDLE, S_RD, S_SCR_RD, S_SCR_WR, S_FILL} state_type;

   localparam logic [ADDR_W-1:0] LAST_CELL  = ADDR_W'(CELLS - 1);
   localparam logic [ADDR_W-1:0] LAST_MOVE  = ADDR_W'((ROWS - 1) * COLUMNS - 1);
   localparam logic [ADDR_W-1:0] BOTTOM_ROW = ADDR_W'((ROWS - 1) * COLUMNS);

   state_type          state_ff, state_in;
   logic [ROW_W-1:0]   row_ff, row_in;
   logic [COL_W-1:0]   col_ff, col_in;
   logic [PHASE_W-1:0] phase_ff, phase_in;
   logic [ADDR_W-1:0]  ptr_ff, ptr_in;
   logic               fill_rsp_ff, fill_rsp_in;
   logic               scroll_ff, scroll_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [15:0]        rsp_cell_ff, rsp_cell_in;
   logic               rsp_scrolled_ff, rsp_scrolled_in;

   logic               we;
   logic [ADDR_W-1:0]  waddr, raddr;
   logic [15:0]        wdata, rdata;
   logic [7:0]         attr;
   logic [15:0]        blank;
   logic [NCOL_W-1:0]  col_inc, tab_col;
   logic [ROW_W:0]     row_next;
   logic [PHASE_W-1:0] phase_inc, phase_dec;
   logic               pop;
   logic [POS_W-1:0]   cursor_pos;

   ctw_ram #(.WIDTH(16), .DEPTH(CELLS)) u_store (
      .clock (clock),
      .we    (we),
      .waddr (waddr),
      .wdata (wdata),
      .raddr (raddr),
      .rdata (rdata)
   );

   assign attr      = {bg_color, fg_color};
   assign blank     = fill_rsp_ff ? {attr, CH_BLANK} : {RESET_BG, RESET_FG, CH_BLANK};
   assign col_inc   = NCOL_W'(col_ff) + NCOL_W'(1);
   assign tab_col   = NCOL_W'(col_ff) + NCOL_W'(TAB_WIDTH) - NCOL_W'(phase_ff);
   assign phase_inc = (phase_ff == PHASE_W'(TAB_WIDTH - 1)) ? '0 : phase_ff + PHASE_W'(1);
   assign phase_dec = (phase_ff == '0) ? PHASE_W'(TAB_WIDTH - 1) : phase_ff - PHASE_W'(1);

   always_comb begin
      state_in        = state_ff;
      row_in          = row_ff;
      col_in          = col_ff;
      phase_in        = phase_ff;
      ptr_in          = ptr_ff;
      fill_rsp_in     = fill_rsp_ff;
      scroll_in       = scroll_ff;
      rsp_valid_in    = 1'b0;
      rsp_cell_in     = 16'd0;
      rsp_scrolled_in = 1'b0;
      we              = 1'b0;
      waddr           = ptr_ff;
      wdata           = blank;
      raddr           = ptr_ff + ADDR_W'(COLUMNS);
      row_next        = {1'b0, row_ff};
      pop             = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (head.valid) begin
               pop = 1'b1;
               case (head.item.op)
                  OP_NL, OP_CR, OP_TAB, OP_BS, OP_CHAR: begin
                     case (head.item.op)
                        OP_NL: begin
                           col_in   = '0;
                           phase_in = '0;
                           row_next = {1'b0, row_ff} + (ROW_W+1)'(1);
                        end
                        OP_CR: begin
                           col_in   = '0;
                           phase_in = '0;
                        end
                        OP_TAB: begin
                           phase_in = '0;
                           if (tab_col >= NCOL_W'(COLUMNS)) begin
                              col_in   = '0;
                              row_next = {1'b0, row_ff} + (ROW_W+1)'(1);
                           end else begin
                              col_in = tab_col[COL_W-1:0];
                           end
                        end
                        OP_BS: begin
                           if (col_ff != '0) begin
                              col_in   = col_ff - COL_W'(1);
                              phase_in = phase_dec;
                              we       = 1'b1;
                              waddr    = ADDR_W'(cell_addr(row_ff, col_ff - COL_W'(1)));
                              wdata    = {attr, CH_BLANK};
                           end
                        end
                        default: begin
                           we    = 1'b1;
                           waddr = ADDR_W'(cell_addr(row_ff, col_ff));
                           wdata = {attr, head.item.char_code};
                           if (col_inc >= NCOL_W'(COLUMNS)) begin
                              col_in   = '0;
                              phase_in = '0;
                              row_next = {1'b0, row_ff} + (ROW_W+1)'(1);
                           end else begin
                              col_in   = col_inc[COL_W-1:0];
                              phase_in = phase_inc;
                           end
                        end
                     endcase
                     if (row_next == (ROW_W+1)'(ROWS)) begin
                        // move rows up, then blank the bottom row
                        row_in   = ROW_W'(ROWS - 1);
                        ptr_in   = '0;
                        state_in = S_SCR_RD;
                     end else begin
                        row_in       = row_next[ROW_W-1:0];
                        rsp_valid_in = 1'b1;
                     end
                  end
                  OP_READ: begin
                     if (head.item.read_ok) begin
                        raddr    = head.item.read_addr;
                        state_in = S_RD;
                     end else begin
                        rsp_valid_in = 1'b1;
                     end
                  end
                  OP_CLEAR: begin
                     row_in      = '0;
                     col_in      = '0;
                     phase_in    = '0;
                     ptr_in      = '0;
                     fill_rsp_in = 1'b1;
                     scroll_in   = 1'b0;
                     state_in    = S_FILL;
                  end
                  default: rsp_valid_in = 1'b1;
               endcase
            end
         end
         S_RD: begin
            rsp_valid_in = 1'b1;
            rsp_cell_in  = rdata;
            state_in     = S_IDLE;
         end
         S_SCR_RD: begin
            state_in = S_SCR_WR;
         end
         S_SCR_WR: begin
            we    = 1'b1;
            wdata = rdata;
            if (ptr_ff == LAST_MOVE) begin
               ptr_in      = BOTTOM_ROW;
               fill_rsp_in = 1'b1;
               scroll_in   = 1'b1;
               state_in    = S_FILL;
            end else begin
               ptr_in   = ptr_ff + ADDR_W'(1);
               state_in = S_SCR_RD;
            end
         end
         S_FILL: begin
            we = 1'b1;
            if (ptr_ff == LAST_CELL) begin
               state_in        = S_IDLE;
               rsp_valid_in    = fill_rsp_ff;
               rsp_scrolled_in = scroll_ff;
            end else begin
               ptr_in = ptr_ff + ADDR_W'(1);
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      rsp_cell_ff     <= rsp_cell_in;
      rsp_scrolled_ff <= rsp_scrolled_in;
      scroll_ff       <= scroll_in;
      if (reset) begin
         state_ff     <= S_FILL;
         row_ff       <= '0;
         col_ff       <= '0;
         phase_ff     <= '0;
         fill_rsp_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         ptr_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         row_ff       <= row_in;
         col_ff       <= col_in;
         phase_ff     <= phase_in;
         fill_rsp_ff  <= fill_rsp_in;
         rsp_valid_ff <= rsp_valid_in;
         ptr_ff       <= ptr_in;
      end
   end

   assign status.pop       = pop;
   assign status.init_busy = (state_ff == S_FILL) && !fill_rsp_ff;

   assign cursor_pos          = cell_addr(row_ff, col_ff);
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_cell_value      = rsp_valid_ff ? rsp_cell_ff : 16'd0;
   assign rsp_scrolled        = rsp_valid_ff && rsp_scrolled_ff;
   assign rsp_cursor_position = cursor_pos[10:0];
endmodule
`default_nettype wire

// ===== rtl/ctw_checker.sv =====
// Port-level checks for text_console_writer, bound to the top level.
// Depends on ctw_pkg.
`default_nettype none
module ctw_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        busy,
   input wire logic        rsp_valid,
   input wire logic [15:0] rsp_cell_value,
   input wire logic [10:0] rsp_cursor_position,
   input wire logic        rsp_scrolled
);
   import ctw_pkg::*;

   // the store clearing pass holds off requests right after reset
   a_busy_after_reset: assert property (@(posedge clock)
      disable iff (reset) $past(reset) |-> busy)
      else $error("busy low right after reset");

   a_quiet_outputs: assert property (@(posedge clock)
      disable iff (reset) !rsp_valid |-> (rsp_cell_value == 16'd0) && !rsp_scrolled)
      else $error("result fields active without strobe");

   // a scroll always leaves the cursor at the start of the bottom row
   a_scroll_cursor: assert property (@(posedge clock)
      disable iff (reset) rsp_scrolled |-> rsp_cursor_position == 11'((ROWS - 1) * COLUMNS))
      else $error("cursor not on bottom row after scroll");
endmodule

bind text_console_writer ctw_checker u_ctw_checker (
   .clock               (clock),
   .reset               (reset),
   .busy                (busy),
   .rsp_valid           (rsp_valid),
   .rsp_cell_value      (rsp_cell_value),
   .rsp_cursor_position (rsp_cursor_position),
   .rsp_scrolled        (rsp_scrolled)
);
`default_nettype wire

// ===== tb/testbench.sv =====
// Self-checking bench for the text console writer: random and directed requests
// checked against an in-bench model of screen store, cursor and colors.
// Depends on ctw_pkg and text_console_writer.
`timescale 1ns / 1ps
`default_nettype none
module testbench;
   import ctw_pkg::*;

   typedef enum logic [1:0] {K_REQUEST, K_CSR, K_DRAIN} step_kind_type;

   typedef struct {
      step_kind_type kind;
      logic [1:0]    cmd;
      logic [7:0]    char_code;
      logic [4:0]    row;
      logic [6:0]    col;
      logic          csr_idx;
      logic [3:0]    csr_data;
      int            gap;
   } plan_step_type;

   typedef struct {
      logic [15:0] cell_val;
      logic [10:0] pos;
      logic        scrolled;
   } console_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [1:0]  req_cmd = '0;
   logic [7:0]  req_char_code = '0;
   logic [4:0]  req_read_row = '0;
   logic [6:0]  req_read_col = '0;
   logic        rsp_valid;
   logic [15:0] rsp_cell_value;
   logic [10:0] rsp_cursor_position;
   logic        rsp_scrolled;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic        csr_index = 1'b0;
   logic [3:0]  csr_wdata = '0;

   text_console_writer dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // console model
   logic [15:0] screen_copy [CELLS];
   int          cur_row, cur_col;
   logic [3:0]  fg_color, bg_color;

   plan_step_type      request_plan[$];
   console_result_type awaited_results[$];
   int                 errors = 0;
   logic               took = 1'b0, csr_took = 1'b0;
   int                 quiet = 0;
   bit                 have = 1'b0;
   bit                 gapless = 1'b0;
   plan_step_type      cur;
   int                 hold;

   function automatic logic [15:0] attr_cell(input logic [7:0] ch);
      return {bg_color, fg_color, ch};
   endfunction

   task automatic predict_console(input logic [1:0] cmd, input logic [7:0] ch,
                                  input logic [4:0] row, input logic [6:0] col);
      console_result_type r;
      r.cell_val = '0;
      r.scrolled = 1'b0;
      if (cmd == CMD_PUT) begin
         if (ch == CH_NL) begin
            cur_col = 0;
            cur_row++;
         end else if (ch == CH_CR) begin
            cur_col = 0;
         end else if (ch == CH_TAB) begin
            cur_col = (cur_col / TAB_WIDTH + 1) * TAB_WIDTH;
            if (cur_col >= COLUMNS) begin
               cur_col = 0;
               cur_row++;
            end
         end else if (ch == CH_BS) begin
            if (cur_col > 0) begin
               cur_col--;
               screen_copy[cur_row * COLUMNS + cur_col] = attr_cell(CH_BLANK);
            end
         end else begin
            screen_copy[cur_row * COLUMNS + cur_col] = attr_cell(ch);
            cur_col++;
            if (cur_col >= COLUMNS) begin
               cur_col = 0;
               cur_row++;
            end
         end
         if (cur_row >= ROWS) begin
            for (int i = 0; i < (ROWS - 1) * COLUMNS; i++)
               screen_copy[i] = screen_copy[i + COLUMNS];
            for (int i = (ROWS - 1) * COLUMNS; i < CELLS; i++)
               screen_copy[i] = attr_cell(CH_BLANK);
            cur_row = ROWS - 1;
            r.scrolled = 1'b1;
         end
      end else if (cmd == CMD_READ) begin
         if (row < ROWS && col < COLUMNS)
            r.cell_val = screen_copy[row * COLUMNS + col];
      end else if (cmd == CMD_CLEAR) begin
         for (int i = 0; i < CELLS; i++)
            screen_copy[i] = attr_cell(CH_BLANK);
         cur_row = 0;
         cur_col = 0;
      end
      r.pos = 11'(cur_row * COLUMNS + cur_col);
      awaited_results.push_back(r);
   endtask

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("mismatch %0t: %s got %0d expected %0d", $realtime, what, got, want);
      errors++;
   endtask

   // acceptance, prediction and result check
   always @(posedge clock) begin
      console_result_type e;
      if (reset) begin
         for (int i = 0; i < CELLS; i++)
            screen_copy[i] = {4'(RESET_BG), 4'(RESET_FG), CH_BLANK};
         cur_row = 0;
         cur_col = 0;
         fg_color = RESET_FG;
         bg_color = RESET_BG;
         took <= 1'b0;
         csr_took <= 1'b0;
         quiet <= 0;
      end else begin
         if (rsp_valid) begin
            if (awaited_results.size() == 0) begin
               report_mismatch("unexpected result, cursor", rsp_cursor_position, -1);
            end else begin
               e = awaited_results.pop_front();
               if (rsp_cell_value !== e.cell_val)
                  report_mismatch("cell_value", rsp_cell_value, e.cell_val);
               if (rsp_cursor_position !== e.pos)
                  report_mismatch("cursor_position", rsp_cursor_position, e.pos);
               if (rsp_scrolled !== e.scrolled)
                  report_mismatch("scrolled", rsp_scrolled, e.scrolled);
            end
         end
         if (start && !busy)
            predict_console(req_cmd, req_char_code, req_read_row, req_read_col);
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_FG) fg_color = csr_wdata;
            else bg_color = csr_wdata;
         end
         took <= start && !busy;
         csr_took <= csr_valid && csr_ready;
         quiet <= (awaited_results.size() == 0 && !busy && !start) ? quiet + 1 : 0;
      end
   end

   // request and register driver
   always @(negedge clock) begin
      logic nstart, ncsr;
      nstart = start;
      ncsr = csr_valid;
      if (!reset) begin
         if (start && took) begin
            nstart = 1'b0;
            have = 1'b0;
         end
         if (csr_valid && csr_took) begin
            ncsr = 1'b0;
            have = 1'b0;
         end
         if (!have && request_plan.size() > 0) begin
            cur = request_plan.pop_front();
            have = 1'b1;
            hold = cur.gap;
         end
         if (have && !nstart && !ncsr) begin
            if (hold > 0) begin
               hold--;
            end else begin
               case (cur.kind)
                  K_REQUEST: begin
                     nstart = 1'b1;
                     req_cmd <= cur.cmd;
                     req_char_code <= cur.char_code;
                     req_read_row <= cur.row;
                     req_read_col <= cur.col;
                  end
                  K_CSR: if (quiet >= 4) begin
                     ncsr = 1'b1;
                     csr_index <= cur.csr_idx;
                     csr_wdata <= cur.csr_data;
                  end
                  default: if (quiet >= 1) have = 1'b0;
               endcase
            end
         end
      end
      start <= nstart;
      csr_valid <= ncsr;
   end

   task automatic add_request(input logic [1:0] cmd, input logic [7:0] ch,
                              input logic [4:0] row, input logic [6:0] col);
      plan_step_type s;
      s.kind = K_REQUEST;
      s.cmd = cmd;
      s.char_code = ch;
      s.row = row;
      s.col = col;
      s.csr_idx = 1'b0;
      s.csr_data = '0;
      s.gap = gapless ? 0 : $urandom_range(0, 10);
      request_plan.push_back(s);
   endtask

   task automatic add_csr(input logic idx, input logic [3:0] data);
      plan_step_type s;
      s.kind = K_CSR;
      s.cmd = '0;
      s.char_code = '0;
      s.row = '0;
      s.col = '0;
      s.csr_idx = idx;
      s.csr_data = data;
      s.gap = 0;
      request_plan.push_back(s);
   endtask

   task automatic add_drain();
      plan_step_type s;
      s = '{K_DRAIN, 2'd0, 8'd0, 5'd0, 7'd0, 1'b0, 4'd0, 0};
      request_plan.push_back(s);
   endtask

   task automatic add_random_request();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 62)
         add_request(CMD_PUT, 8'($urandom_range(0, 255)), '0, '0);
      else if (pick < 77) begin
         if ($urandom_range(0, 9) == 0)
            add_request(CMD_READ, 8'($urandom), 5'($urandom), 7'($urandom));
         else
            add_request(CMD_READ, 8'($urandom), 5'($urandom_range(0, ROWS - 1)),
                        7'($urandom_range(0, COLUMNS - 1)));
      end
      else if (pick < 80) add_request(CMD_PUT, CH_NL, 5'($urandom), 7'($urandom));
      else if (pick < 85) add_request(CMD_PUT, CH_TAB, '0, '0);
      else if (pick < 87) add_request(CMD_PUT, CH_CR, '0, '0);
      else if (pick < 93) add_request(CMD_PUT, CH_BS, '0, '0);
      else if (pick < 94) add_request(CMD_CLEAR, 8'($urandom), 5'($urandom), 7'($urandom));
      else add_request(2'd3, 8'($urandom), 5'($urandom), 7'($urandom));
   endtask

   initial begin
      logic [3:0] fg_set [6] = '{4'd0, 4'd15, 4'd10, 4'd5, 4'd3, 4'd12};
      logic [3:0] bg_set [6] = '{4'd15, 4'd0, 4'd5, 4'd10, 4'd12, 4'd3};
      // directed opening with reset colors
      add_request(CMD_READ, 8'h00, 5'd0, 7'd0);
      add_request(CMD_PUT, 8'h41, '0, '0);
      add_request(CMD_PUT, 8'h00, '0, '0);
      add_request(CMD_PUT, 8'hFF, '0, '0);
      add_request(CMD_PUT, 8'h80, '0, '0);
      add_request(CMD_PUT, 8'h7F, '0, '0);
      add_request(CMD_PUT, CH_BS, '0, '0);
      add_request(CMD_PUT, CH_TAB, '0, '0);
      add_request(CMD_PUT, CH_CR, '0, '0);
      add_request(CMD_PUT, CH_BS, '0, '0);
      add_request(CMD_PUT, CH_NL, '0, '0);
      add_request(CMD_READ, 8'hFF, 5'd0, 7'd1);
      add_request(CMD_READ, 8'h00, 5'd24, 7'd79);
      add_request(CMD_READ, 8'h00, 5'd25, 7'd0);
      add_request(CMD_READ, 8'h00, 5'd0, 7'd80);
      add_request(CMD_READ, 8'h00, 5'd31, 7'd127);
      add_request(2'd3, 8'hFF, 5'd31, 7'd127);
      for (int i = 0; i < 10; i++) add_request(CMD_PUT, CH_TAB, '0, '0);
      // walk to the bottom row and past it
      for (int i = 0; i < 26; i++) add_request(CMD_PUT, CH_NL, '0, '0);
      add_request(CMD_READ, 8'h00, 5'd23, 7'd0);
      add_request(CMD_CLEAR, 8'h00, '0, '0);
      for (int p = 0; p < 6; p++) begin
         add_drain();
         add_csr(CSR_FG, fg_set[p]);
         add_csr(CSR_BG, bg_set[p]);
         gapless = (p % 3 == 1);
         for (int i = 0; i < 155; i++) begin
            if (i == 78) add_drain();
            if (i % 40 == 0) gapless = ~gapless;
            add_random_request();
         end
         // run of 75 printable characters, then a tab
         for (int i = 0; i < 75; i++) add_request(CMD_PUT, 8'($urandom_range(32, 126)), '0, '0);
         add_request(CMD_PUT, CH_TAB, '0, '0);
      end
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      wait (request_plan.size() == 0 && !have && awaited_results.size() == 0);
      repeat (4000) @(posedge clock);
      if (errors == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

   initial begin
      #50ms;
      $display("Verification failed");
      $finish;
   end
endmodule
`default_nettype wire
